[rtl/core/base64_stream_codec_unit_assert.svh]
// ---------------------------------------------------------------------------
// base64_stream_codec_unit assertion macros
// Concurrent checks for simulation; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64_STREAM_CODEC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define B64SC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("b64sc: property failed");
`define B64SC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("b64sc: forbidden condition seen");
`else
`define B64SC_ASSERT(lbl, clk, rstn, prop)
`define B64SC_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[rtl/core/b64sc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ---------------------------------------------------------------------------
package b64sc_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    typedef enum logic [1:0] {
        POS_0 = 2'd0,
        POS_1 = 2'd1,
        POS_2 = 2'd2,
        POS_3 = 2'd3
    } pos_t;

    // One accepted item worth of results: one or two output bytes
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       two;
        logic       last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'd65;        // 'A'
        else if (v < 6'd52)
            return w + 8'd71;        // 'a' - 26
        else if (v < 6'd62)
            return w - 8'd4;         // '0' - 52
        else if (v == 6'd62)
            return 8'd43;            // '+'
        else
            return 8'd47;            // '/'
    endfunction

    // Character to 6-bit value; anything outside the alphabet reads as zero
    function automatic logic [5:0] dec_char(input logic [7:0] c);
        if (c >= 8'd65 && c <= 8'd90)
            return 6'(c - 8'd65);
        else if (c >= 8'd97 && c <= 8'd122)
            return 6'(c - 8'd71);
        else if (c >= 8'd48 && c <= 8'd57)
            return 6'(c + 8'd4);
        else if (c == 8'd43)
            return 6'd62;
        else if (c == 8'd47)
            return 6'd63;
        else
            return 6'd0;
    endfunction

endpackage

[rtl/core/b64sc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64sc_front
// Accepts input transfers, tracks the group, builds at most one job per transfer.
// ---------------------------------------------------------------------------
`include "base64_stream_codec_unit_assert.svh"

module b64sc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tlast,
    output logic                push,
    output b64sc_pkg::job_t     push_entry,
    input  b64sc_pkg::q_status_t q_status
);
    import b64sc_pkg::*;

    dir_t       dir_reg,  dir_next;
    pos_t       pos_reg,  pos_next;
    logic [5:0] left_reg, left_next;
    logic       accept;
    logic       has_result;
    logic [5:0] dval;
    pos_t       pos_work;
    logic [5:0] left_work;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign dval          = dec_char(s_axis_tdata);

    always_comb
    begin
        pos_work          = pos_reg;
        left_work         = left_reg;
        has_result        = 1'b0;
        push_entry.first  = '0;
        push_entry.second = '0;
        push_entry.two    = 1'b0;
        push_entry.last   = s_axis_tlast;

        if (dir_reg == DIR_ENCODE)
        begin
            has_result = 1'b1;
            unique case (pos_reg) inside
                POS_2:
                begin
                    push_entry.first  = enc_char(left_reg | {4'b0, s_axis_tdata[7:6]});
                    push_entry.second = enc_char(s_axis_tdata[5:0]);
                    push_entry.two    = 1'b1;
                    pos_work          = POS_0;
                    left_work         = '0;
                end
                POS_1:
                begin
                    push_entry.first = enc_char(left_reg | {2'b0, s_axis_tdata[7:4]});
                    left_work        = {s_axis_tdata[3:0], 2'b0};
                    pos_work         = POS_2;
                end
                POS_0, POS_3:
                begin
                    push_entry.first = enc_char(s_axis_tdata[7:2]);
                    left_work        = {s_axis_tdata[1:0], 4'b0};
                    pos_work         = POS_1;
                end
            endcase
            // flush the zero-filled partial group
            if (s_axis_tlast && pos_work != POS_0)
            begin
                push_entry.second = enc_char(left_work);
                push_entry.two    = 1'b1;
            end
        end
        else
        begin
            unique case (pos_reg)
                POS_0:
                begin
                    left_work = dval;
                    pos_work  = POS_1;
                end
                POS_1:
                begin
                    push_entry.first = {left_reg, dval[5:4]};
                    has_result       = 1'b1;
                    left_work        = {2'b0, dval[3:0]};
                    pos_work         = POS_2;
                end
                POS_2:
                begin
                    push_entry.first = {left_reg[3:0], dval[5:2]};
                    has_result       = 1'b1;
                    left_work        = {4'b0, dval[1:0]};
                    pos_work         = POS_3;
                end
                POS_3:
                begin
                    push_entry.first = {left_reg[1:0], dval};
                    has_result       = 1'b1;
                    left_work        = '0;
                    pos_work         = POS_0;
                end
            endcase
        end
    end

    assign push = accept && has_result;

    always_comb
    begin
        dir_next  = dir_reg;
        pos_next  = pos_reg;
        left_next = left_reg;
        if (cfg_valid && cfg_ready)
        begin
            dir_next  = dir_t'(cfg_data);
            pos_next  = POS_0;
            left_next = '0;
        end
        else if (accept)
        begin
            // end of message drops any partial group
            pos_next  = s_axis_tlast ? POS_0 : pos_work;
            left_next = s_axis_tlast ? 6'd0 : left_work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= DIR_ENCODE;
            pos_reg  <= POS_0;
            left_reg <= '0;
        end
        else
        begin
            dir_reg  <= dir_next;
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

    `B64SC_ASSERT(front_enc_pos, clk, rst_n, (dir_reg == DIR_ENCODE) |-> (pos_reg != POS_3))

endmodule

[rtl/core/b64sc_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64sc_queue
// Short job queue between front and back end.
// ---------------------------------------------------------------------------
`include "base64_stream_codec_unit_assert.svh"

module b64sc_queue #(
    parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b64sc_pkg::job_t      push_entry,
    input  logic                 pop,
    output b64sc_pkg::job_t      head,
    output b64sc_pkg::q_status_t q_status
);
    import b64sc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `B64SC_ASSERT(q_no_overflow, clk, rst_n, push |-> !q_status.full)
    `B64SC_ASSERT(q_no_underflow, clk, rst_n, pop |-> !q_status.empty)
    `B64SC_NEVER(q_count_range, clk, rst_n, count_reg > CNT_W'(DEPTH))

endmodule

[rtl/core/b64sc_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64sc_back
// Drains jobs from the queue and sends their bytes, one per transfer.
// ---------------------------------------------------------------------------
`include "base64_stream_codec_unit_assert.svh"

module b64sc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64sc_pkg::job_t      head,
    input  b64sc_pkg::q_status_t q_status,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,
    output logic                 m_axis_tlast
);
    import b64sc_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg,  out_data_next;
    logic       out_last_reg,  out_last_next;
    logic       sec_valid_reg, sec_valid_next;
    logic [7:0] sec_data_reg,  sec_data_next;
    logic       sec_last_reg,  sec_last_next;
    logic       load;

    assign load = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        sec_valid_next = sec_valid_reg;
        sec_data_next  = sec_data_reg;
        sec_last_next  = sec_last_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (sec_valid_reg)
            begin
                // second byte of the previous job goes first
                out_valid_next = 1'b1;
                out_data_next  = sec_data_reg;
                out_last_next  = sec_last_reg;
                sec_valid_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                out_valid_next = 1'b1;
                out_data_next  = head.first;
                out_last_next  = head.last && !head.two;
                sec_valid_next = head.two;
                sec_data_next  = head.second;
                sec_last_next  = head.last;
                pop            = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        sec_data_reg <= sec_data_next;
        sec_last_reg <= sec_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `B64SC_ASSERT(back_sec_behind_out, clk, rst_n, sec_valid_reg |-> out_valid_reg)
    `B64SC_ASSERT(back_first_not_last, clk, rst_n, sec_valid_reg |-> !out_last_reg)

endmodule

[rtl/core/base64_stream_codec_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_codec_unit
// Unpadded streaming base64 encoder/decoder.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data writes the direction (0 encode, 1 decode)
//   and clears the group; write it only while the block is idle.
//   s_axis carries data_in in tdata and end_of_message in tlast.
//   m_axis carries data_out in tdata and last_out in tlast.
//   Encode: each byte gives one or two characters; the last byte of a
//   message flushes a partial group as one zero-filled character.
//   Decode: each character gives at most one byte; leftover bits are
//   dropped at the end of a message.
// Timing:
//   A result passes through the job queue and then the output register
//   before m_axis_tvalid rises. One result leaves per cycle while
//   m_axis_tready stays high; decoding then takes one character per cycle.
//   The single output register paces this; the job queue absorbs bursts.
// Reset clears direction (encode), group state, queue and output valid.
// When m_axis stalls the output holds, the queue fills and s_axis_tready
// drops once QUEUE_DEPTH jobs wait.
// ---------------------------------------------------------------------------
module base64_stream_codec_unit #(
    parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,       // direction
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_in
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_out
    output logic       m_axis_tlast
);
    import b64sc_pkg::*;

    logic      push;
    logic      pop;
    job_t      push_entry;
    job_t      head;
    q_status_t q_status;

    b64sc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_entry    (push_entry),
        .q_status      (q_status)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    b64sc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[sim/base64_stream_codec_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_codec_unit_test
// Self-checking bench for the unpadded base64 stream codec. A short table of
// directed transfers comes first, then random messages in both directions.
// Typed rows are checked by the table, others by a cycle-free bench codec model.
// ---------------------------------------------------------------------------
module base64_stream_codec_unit_test;
    import b64sc_pkg::*;

    localparam int NUM_ROWS        = 27;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int IDLE_SLACK      = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef enum logic {
        STEP_ITEM   = 1'b0,
        STEP_SETDIR = 1'b1
    } step_kind_t;

    // Typed rows carry their expected bytes; the final one carries the end mark
    typedef struct packed {
        step_kind_t kind;
        logic [7:0] data;
        logic       eom;
        logic       typed;
        logic [1:0] n_res;
        logic [7:0] res0;
        logic [7:0] res1;
    } row_t;

    localparam row_t DIRECTED [NUM_ROWS] = '{
        // encode, direction from reset
        '{STEP_ITEM,   8'h00, 1'b1, 1'b1, 2'd2, 8'h41, 8'h41},
        '{STEP_ITEM,   8'hFF, 1'b1, 1'b1, 2'd2, 8'h2F, 8'h77},
        '{STEP_ITEM,   8'h4D, 1'b0, 1'b1, 2'd1, 8'h54, 8'h00},
        '{STEP_ITEM,   8'h61, 1'b0, 1'b1, 2'd1, 8'h57, 8'h00},
        '{STEP_ITEM,   8'h6E, 1'b1, 1'b1, 2'd2, 8'h46, 8'h75},
        '{STEP_ITEM,   8'hFF, 1'b0, 1'b1, 2'd1, 8'h2F, 8'h00},
        '{STEP_ITEM,   8'hFF, 1'b1, 1'b1, 2'd2, 8'h2F, 8'h38},
        '{STEP_ITEM,   8'hA5, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h5A, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'hC3, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        // leave a partial group open; the direction write must clear it
        '{STEP_ITEM,   8'h12, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_SETDIR, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h80, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_SETDIR, 8'h01, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        // decode
        '{STEP_ITEM,   8'h54, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h57, 1'b0, 1'b1, 2'd1, 8'h4D, 8'h00},
        '{STEP_ITEM,   8'h46, 1'b0, 1'b1, 2'd1, 8'h61, 8'h00},
        '{STEP_ITEM,   8'h75, 1'b1, 1'b1, 2'd1, 8'h6E, 8'h00},
        // one character then end of message: nothing comes out
        '{STEP_ITEM,   8'h51, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h2F, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h2F, 1'b1, 1'b1, 2'd1, 8'hFF, 8'h00},
        // pad character and a non-alphabet byte both read as zero
        '{STEP_ITEM,   8'h3D, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'hFF, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h2B, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h7A, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h39, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{STEP_ITEM,   8'h61, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // codec model state
    dir_t       codec_dir = DIR_ENCODE;
    pos_t       grp_pos = POS_0;
    logic [5:0] held_bits = '0;

    beat_t      pending_beats[$];
    bit         tx_quiet = 1'b0;
    bit         rx_quiet = 1'b0;
    int         fail_count = 0;
    int         n_items = 0;
    int         n_results = 0;
    int         n_msgs = 0;
    int         n_cfg = 0;

    base64_stream_codec_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] char_of_sextet(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + {2'b00, v};                 // 'A'..'Z'
        else if (v < 6'd52)
            return 8'h61 + {2'b00, v - 6'd26};         // 'a'..'z'
        else if (v < 6'd62)
            return 8'h30 + {2'b00, v - 6'd52};         // '0'..'9'
        else if (v == 6'd62)
            return 8'h2B;                              // '+'
        else
            return 8'h2F;                              // '/'
    endfunction

    function automatic logic [5:0] sextet_of_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            return 6'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            return 6'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            return 6'd62;
        else if (c == 8'h2F)
            return 6'd63;
        else
            return 6'd0;
    endfunction

    // Advance the codec model by one input byte; returns the number of results
    function automatic int step_codec(input logic [7:0] d, input logic eom,
                                      output beat_t r0, output beat_t r1);
        logic [5:0] sx;
        int         n;
        r0 = '0;
        r1 = '0;
        n  = 0;
        if (codec_dir == DIR_ENCODE)
        begin
            case (grp_pos)
                POS_2:
                begin
                    r0.data   = char_of_sextet(held_bits | {4'b0, d[7:6]});
                    r1.data   = char_of_sextet(d[5:0]);
                    n         = 2;
                    grp_pos   = POS_0;
                    held_bits = '0;
                end
                POS_1:
                begin
                    r0.data   = char_of_sextet(held_bits | {2'b0, d[7:4]});
                    n         = 1;
                    held_bits = {d[3:0], 2'b00};
                    grp_pos   = POS_2;
                end
                default:
                begin
                    r0.data   = char_of_sextet(d[7:2]);
                    n         = 1;
                    held_bits = {d[1:0], 4'b0000};
                    grp_pos   = POS_1;
                end
            endcase
            // flush the zero-filled tail of a partial group
            if (eom && grp_pos != POS_0)
            begin
                r1.data = char_of_sextet(held_bits);
                n       = 2;
            end
        end
        else
        begin
            sx = sextet_of_char(d);
            case (grp_pos)
                POS_0:
                begin
                    held_bits = sx;
                    grp_pos   = POS_1;
                end
                POS_1:
                begin
                    r0.data   = {held_bits, sx[5:4]};
                    n         = 1;
                    held_bits = {2'b00, sx[3:0]};
                    grp_pos   = POS_2;
                end
                POS_2:
                begin
                    r0.data   = {held_bits[3:0], sx[5:2]};
                    n         = 1;
                    held_bits = {4'b0000, sx[1:0]};
                    grp_pos   = POS_3;
                end
                default:
                begin
                    r0.data   = {held_bits[1:0], sx};
                    n         = 1;
                    held_bits = '0;
                    grp_pos   = POS_0;
                end
            endcase
        end
        if (eom)
        begin
            if (n == 1)
                r0.last = 1'b1;
            else if (n == 2)
                r1.last = 1'b1;
            grp_pos   = POS_0;
            held_bits = '0;
        end
        return n;
    endfunction

    // Wait out the sender gap, then hold the byte until the transfer
    task automatic transfer_byte(input logic [7:0] d, input logic eom);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= eom;
        do @(posedge clk); while (!s_tready);
        n_items++;
        if (eom)
            n_msgs++;
    endtask

    task automatic send_and_predict(input logic [7:0] d, input logic eom);
        beat_t r0;
        beat_t r1;
        int    n;
        transfer_byte(d, eom);
        n = step_codec(d, eom, r0, r1);
        if (n > 0)
            pending_beats.push_back(r0);
        if (n > 1)
            pending_beats.push_back(r1);
    endtask

    // Stop sending, let every expected result arrive, then let the pipe empty
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (IDLE_SLACK) @(posedge clk);
    endtask

    task automatic write_direction(input dir_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        codec_dir = v;
        grp_pos   = POS_0;
        held_bits = '0;
        n_cfg++;
    endtask

    // Result side: random stalls, compare each transfer with the oldest expectation
    initial
    begin
        beat_t want;
        int    gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(rx_quiet);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            n_results++;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result: data_out %02h last_out %0b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_tdata !== want.data)
                begin
                    $error("data_out: expected %02h, actual %02h", want.data, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_out: expected %0b, actual %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        row_t       row;
        beat_t      r0;
        beat_t      r1;
        int         n;
        int         phase;
        int         sent;
        int         len;
        int         k;
        bit         open_msg;
        logic [7:0] d;
        logic       eom;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == STEP_SETDIR)
            begin
                settle_idle();
                write_direction(dir_t'(row.data[0]));
            end
            else if (row.typed)
            begin
                transfer_byte(row.data, row.eom);
                n = step_codec(row.data, row.eom, r0, r1);
                if (row.n_res > 0)
                    pending_beats.push_back(beat_t'{row.res0,
                                                    row.eom && row.n_res == 2'd1});
                if (row.n_res > 1)
                    pending_beats.push_back(beat_t'{row.res1, row.eom});
            end
            else
            begin
                send_and_predict(row.data, row.eom);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle_idle();
            if (phase == 0)
                write_direction(DIR_ENCODE);
            else if (phase == 1)
                write_direction(DIR_DECODE);
            else
                write_direction(dir_t'($urandom_range(0, 1)));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                 : $urandom_range(1, 24);
                // now and then leave a message without its end mark
                open_msg = ($urandom_range(0, 9) == 0);
                for (k = 0; k < len; k++)
                begin
                    if (codec_dir == DIR_DECODE && $urandom_range(0, 99) < 85)
                        d = char_of_sextet(6'($urandom_range(0, 63)));
                    else
                        d = 8'($urandom_range(0, 255));
                    eom = (k == len - 1) && !open_msg;
                    send_and_predict(d, eom);
                    sent++;
                    if ($urandom_range(0, 59) == 0)
                        settle_idle();
                end
            end
        end

        settle_idle();
        $display("Covered %0d input transfers in %0d messages, %0d results checked,",
                 n_items, n_msgs, n_results);
        $display("  %0d direction writes across encode and decode.", n_cfg);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
